FILE: design/dfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg: shared types and constants of the frequency response unit
// Command and status codes, payload structs, queue entry and the CORDIC table.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int COEFF_BITS   = 32;
	localparam int PHASE_BITS   = 16;
	localparam int IDX_BITS     = 4;
	localparam int CNT_BITS     = 5;
	localparam int RES_BITS     = 32;
	localparam int CFG_IDX_BITS = 1;

	localparam int CORDIC_STEPS = 16;
	localparam int STEP_BITS    = 4;
	localparam int ANG_BITS     = 33;
	localparam int XY_BITS      = 34;
	localparam int CS_BITS      = 32;
	localparam int FRAC_BITS    = 30;
	localparam int LO_BITS      = 24;
	localparam int QUOT_BITS    = 32;
	localparam int DIV_CNT_BITS = 5;

	localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [1:0] CMD_WR_NUM = 2'd0;
	localparam logic [1:0] CMD_WR_DEN = 2'd1;
	localparam logic [1:0] CMD_EVAL   = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_DEN_ZERO = 2'd1;
	localparam logic [1:0] STATUS_RANGE    = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COUNT = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DEN_COUNT = 1'b1;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]                   command;
		logic [IDX_BITS-1:0]          coeff_index;
		logic signed [COEFF_BITS-1:0] coeff_value;
		logic [PHASE_BITS-1:0]        phase;
	} request_t;

	typedef struct packed {
		logic signed [RES_BITS-1:0] resp_real;
		logic signed [RES_BITS-1:0] resp_imag;
		logic [1:0]                 status;
	} result_t;

	typedef enum logic [1:0] {
		KIND_WR_NUM,
		KIND_WR_DEN,
		KIND_EVAL
	} item_kind_t;

	typedef struct packed {
		item_kind_t                   kind;
		logic [IDX_BITS-1:0]          addr;
		logic signed [COEFF_BITS-1:0] value;
		logic [PHASE_BITS-1:0]        phase;
	} queue_item_t;

	// atan(2^-i) as a fraction of a full turn, 2^32 per turn
	function automatic logic signed [ANG_BITS-1:0] turn_atan(input logic [STEP_BITS-1:0] i);
		logic signed [ANG_BITS-1:0] v;
		case (i)
			4'd0:    v = 33'sd536870912;
			4'd1:    v = 33'sd316933406;
			4'd2:    v = 33'sd167458907;
			4'd3:    v = 33'sd85004756;
			4'd4:    v = 33'sd42667331;
			4'd5:    v = 33'sd21354465;
			4'd6:    v = 33'sd10679838;
			4'd7:    v = 33'sd5340245;
			4'd8:    v = 33'sd2670163;
			4'd9:    v = 33'sd1335087;
			4'd10:   v = 33'sd667544;
			4'd11:   v = 33'sd333772;
			4'd12:   v = 33'sd166886;
			4'd13:   v = 33'sd83443;
			4'd14:   v = 33'sd41722;
			4'd15:   v = 33'sd20861;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: design/digital_frequency_response_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// digital_frequency_response_unit: rational filter response H(e^jw)
// Holds numerator and denominator coefficients and evaluates H at a phase.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken on a clock edge with start high and busy low. Write
//   commands store a Q8.24 coefficient at an index; an evaluate command
//   gives one result, Q16.16 real and imaginary parts plus status, on the
//   result port for one cycle with result_valid high. The receiver cannot
//   stall: the result must be captured in that cycle.
//   Commands pass through a two-entry queue, so busy rises only when two
//   items are waiting. A write is done in the execution stage as it is popped.
//   An evaluate runs 16 CORDIC steps, a Horner pass of low half, high half
//   and add steps per tap in the shared multipliers over max(nb, na) taps,
//   nb and na being the tap counts in use, serial products over
//   ACC_W = 34 + log2(MAX_TAPS) bits and a restoring divide to 32 bits.
//   The user must write the tap counts through cfg_we/cfg_index/cfg_data
//   only while the unit is idle; the block itself does not enforce this.
//   Reset makes both stores read as zero and sets both counts to one.
// ----------------------------------------------------------------------------
module digital_frequency_response_unit #(
	parameter int MAX_TAPS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire dfr_pkg::request_t                 request,
	input  wire logic                              cfg_we,
	input  wire logic [dfr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [dfr_pkg::CNT_BITS-1:0]      cfg_data,
	output logic                                   result_valid,
	output dfr_pkg::result_t                       result
);
	import dfr_pkg::*;

	logic [CNT_BITS-1:0] num_count_q, den_count_q;
	logic                q_valid, q_pop;
	queue_item_t         q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_count_q <= CNT_BITS'(1);
			den_count_q <= CNT_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_COUNT: num_count_q <= cfg_data;
				CFG_DEN_COUNT: den_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dfr_front #(.MAX_TAPS(MAX_TAPS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.q_valid(q_valid),
		.q_item (q_item),
		.q_pop  (q_pop)
	);

	dfr_back #(.MAX_TAPS(MAX_TAPS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.num_count   (num_count_q),
		.den_count   (den_count_q),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule
`default_nettype wire

FILE: design/dfr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: design/dfr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_front: command intake and item queue
// Drops items with no effect and queues the rest for the back end.
// ----------------------------------------------------------------------------
module dfr_front #(
	parameter int MAX_TAPS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire dfr_pkg::request_t    request,
	output logic                      q_valid,
	output dfr_pkg::queue_item_t      q_item,
	input  wire logic                 q_pop
);
	import dfr_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	queue_item_t    slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]  count_q;
	logic           keep, push;
	queue_item_t    entry;

	always_comb begin
		entry.addr  = request.coeff_index;
		entry.value = request.coeff_value;
		entry.phase = request.phase;
		keep        = 1'b0;
		case (request.command)
			CMD_WR_NUM: begin
				entry.kind = KIND_WR_NUM;
				keep       = int'(request.coeff_index) < MAX_TAPS;
			end
			CMD_WR_DEN: begin
				entry.kind = KIND_WR_DEN;
				keep       = int'(request.coeff_index) < MAX_TAPS;
			end
			CMD_EVAL: begin
				entry.kind = KIND_EVAL;
				keep       = 1'b1;
			end
			default: begin
				entry.kind = KIND_EVAL;
			end
		endcase
	end

	assign busy    = count_q == NW'(QUEUE_DEPTH);
	assign push    = start && !busy && keep;
	assign q_valid = count_q != '0;
	assign q_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/dfr_horner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_horner: coefficient store and complex Horner evaluator
// Evaluates sum c[k] z^k with z = cos - j sin, one tap per pass of low, high and add states.
// ----------------------------------------------------------------------------
module dfr_horner #(
	parameter int MAX_TAPS = 16,
	localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
	localparam int CW    = $clog2(MAX_TAPS + 1),
	localparam int ACC_W = dfr_pkg::COEFF_BITS + $clog2(MAX_TAPS) + 2
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  go,
	input  wire logic [CW-1:0]                         steps,
	input  wire logic [CW-1:0]                         taps,
	input  wire logic signed [dfr_pkg::CS_BITS-1:0]    cos_v,
	input  wire logic signed [dfr_pkg::CS_BITS-1:0]    msin_v,
	input  wire logic                                  wr_en,
	input  wire logic [AW-1:0]                         wr_addr,
	input  wire logic signed [dfr_pkg::COEFF_BITS-1:0] wr_data,
	output logic                                       done,
	output logic signed [ACC_W-1:0]                    acc_re,
	output logic signed [ACC_W-1:0]                    acc_im,
	output logic                                       nonzero
);
	import dfr_pkg::*;

	localparam int HI_W = ACC_W - LO_BITS;
	localparam int MA_W = ((HI_W > LO_BITS) ? HI_W : LO_BITS) + 1;
	localparam int MP_W = MA_W + CS_BITS;
	localparam int FW   = MP_W + LO_BITS + 1;

	typedef enum logic [1:0] {H_IDLE, H_LO, H_HI, H_ADD} hstate_t;

	hstate_t                      state_q;
	logic [AW-1:0]                k_q;
	logic signed [ACC_W-1:0]      ar_q, ai_q;
	logic signed [COEFF_BITS-1:0] coef_q;
	logic                         nz_q;
	logic [MAX_TAPS-1:0]          valid_q;
	logic signed [MP_W-1:0]       plo_q [4];
	logic signed [MP_W-1:0]       phi_q [4];
	logic [COEFF_BITS-1:0]        rdata;
	logic signed [MA_W-1:0]       mop_a [4];
	logic signed [CS_BITS-1:0]    mop_b [4];
	logic signed [MP_W-1:0]       prod  [4];
	logic signed [ACC_W-1:0]      term  [4];
	logic signed [ACC_W-1:0]      src   [4];
	logic signed [FW-1:0]         full  [4];
	logic                         use_tap;

	dfr_ram #(
		.WIDTH(COEFF_BITS),
		.DEPTH(MAX_TAPS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(k_q),
		.rdata(rdata)
	);

	// lanes: ar*c, ai*ms, ar*ms, ai*c; the accumulator goes in as low then high half
	always_comb begin
		src[0]   = ar_q;
		src[1]   = ai_q;
		src[2]   = ar_q;
		src[3]   = ai_q;
		mop_b[0] = cos_v;
		mop_b[1] = msin_v;
		mop_b[2] = msin_v;
		mop_b[3] = cos_v;
		for (int j = 0; j < 4; j++) begin
			if (state_q == H_HI) begin
				mop_a[j] = MA_W'(src[j] >>> LO_BITS);
			end else begin
				mop_a[j] = MA_W'({1'b0, src[j][LO_BITS-1:0]});
			end
			prod[j] = MP_W'(mop_a[j] * mop_b[j]);
			full[j] = (FW'(phi_q[j]) <<< LO_BITS) + FW'(plo_q[j]);
			term[j] = ACC_W'(full[j] >>> FRAC_BITS);
		end
		use_tap = valid_q[k_q] && (CW'(k_q) < taps);
	end

	assign acc_re  = ar_q;
	assign acc_im  = ai_q;
	assign nonzero = nz_q;

	always_ff @(posedge clk) begin
		case (state_q)
			H_LO: begin
				for (int j = 0; j < 4; j++) plo_q[j] <= prod[j];
			end
			H_HI: begin
				for (int j = 0; j < 4; j++) phi_q[j] <= prod[j];
				coef_q <= use_tap ? $signed(rdata) : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			k_q     <= '0;
			ar_q    <= '0;
			ai_q    <= '0;
			nz_q    <= 1'b0;
			done    <= 1'b0;
			valid_q <= '0;
		end else begin
			done <= 1'b0;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				H_IDLE: begin
					if (go) begin
						k_q     <= AW'(steps - 1'b1);
						ar_q    <= '0;
						ai_q    <= '0;
						nz_q    <= 1'b0;
						state_q <= H_LO;
					end
				end
				H_LO: begin
					state_q <= H_HI;
				end
				H_HI: begin
					state_q <= H_ADD;
				end
				H_ADD: begin
					ar_q <= ACC_W'(term[0] - term[1] + coef_q);
					ai_q <= ACC_W'(term[2] + term[3]);
					nz_q <= nz_q || (coef_q != '0);
					if (k_q == '0) begin
						done    <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						k_q     <= k_q - 1'b1;
						state_q <= H_LO;
					end
				end
				default: begin
					state_q <= H_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/dfr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_back: item execution
// Store writes, CORDIC cos/sin, two Horner lanes, serial products and divide.
// ----------------------------------------------------------------------------
module dfr_back #(
	parameter int MAX_TAPS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire dfr_pkg::queue_item_t          q_item,
	output logic                               q_pop,
	input  wire logic [dfr_pkg::CNT_BITS-1:0]  num_count,
	input  wire logic [dfr_pkg::CNT_BITS-1:0]  den_count,
	output logic                               result_valid,
	output dfr_pkg::result_t                   result
);
	import dfr_pkg::*;

	localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW    = $clog2(MAX_TAPS + 1);
	localparam int ACC_W = COEFF_BITS + $clog2(MAX_TAPS) + 2;
	localparam int JW    = $clog2(ACC_W);
	localparam int PW    = 2 * ACC_W + 1;
	localparam int CMPW  = PW + 32;

	typedef enum logic [2:0] {
		B_IDLE, B_CORDIC, B_START, B_HORNER, B_PROD, B_RANGE, B_DIV, B_FIN
	} bstate_t;

	function automatic logic [CW-1:0] eff_count(input logic [CNT_BITS-1:0] n);
		logic [CW-1:0] r;
		if (n == '0) begin
			r = CW'(1);
		end else if (int'(n) > MAX_TAPS) begin
			r = CW'(MAX_TAPS);
		end else begin
			r = CW'(n);
		end
		return r;
	endfunction

	bstate_t                     state_q;
	logic [1:0]                  quad_q;
	logic signed [ANG_BITS-1:0]  z_q;
	logic signed [XY_BITS-1:0]   x_q, y_q;
	logic [STEP_BITS-1:0]        i_q;
	logic signed [CS_BITS-1:0]   cos_q, msin_q;
	logic                        go_q;
	logic [CW-1:0]               nb, na, steps;
	logic [JW-1:0]               j_q;
	logic signed [PW-1:0]        pre_q, pim_q, pden_q;
	logic [PW-1:0]               rre_q, rim_q;
	logic [QUOT_BITS-1:0]        qre_q, qim_q, dre_q, dim_q;
	logic                        neg_re_q, neg_im_q, ovf_re_q, ovf_im_q;
	logic [DIV_CNT_BITS-1:0]     dc_q;
	logic [PHASE_BITS+31:0]      angle;

	logic                        num_done, den_done, den_nz;
	logic signed [ACC_W-1:0]     nr, ni, dr, di;
	logic signed [PW-1:0]        t_re, t_im, t_den, nr_w, ni_w, dr_w, di_w;
	logic                        msb;
	logic [PW-1:0]               mag_re, mag_im, den_u;
	logic [CMPW-1:0]             lim_re, lim_im;
	logic [PW:0]                 s_re, s_im;
	logic                        ge_re, ge_im;
	logic [QUOT_BITS-1:0]        f_re, f_im;

	assign nb    = eff_count(num_count);
	assign na    = eff_count(den_count);
	assign steps = (nb > na) ? nb : na;
	assign q_pop = (state_q == B_IDLE) && q_valid;
	assign angle = {q_item.phase, 32'b0};

	dfr_horner #(.MAX_TAPS(MAX_TAPS)) u_num (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.steps  (steps),
		.taps   (nb),
		.cos_v  (cos_q),
		.msin_v (msin_q),
		.wr_en  (q_pop && q_item.kind == KIND_WR_NUM),
		.wr_addr(AW'(q_item.addr)),
		.wr_data(q_item.value),
		.done   (num_done),
		.acc_re (nr),
		.acc_im (ni),
		.nonzero()
	);

	dfr_horner #(.MAX_TAPS(MAX_TAPS)) u_den (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.steps  (steps),
		.taps   (na),
		.cos_v  (cos_q),
		.msin_v (msin_q),
		.wr_en  (q_pop && q_item.kind == KIND_WR_DEN),
		.wr_addr(AW'(q_item.addr)),
		.wr_data(q_item.value),
		.done   (den_done),
		.acc_re (dr),
		.acc_im (di),
		.nonzero(den_nz)
	);

	// accumulators stay far below 2^54, so no common prescale is ever needed
	always_comb begin
		nr_w  = PW'(nr);
		ni_w  = PW'(ni);
		dr_w  = PW'(dr);
		di_w  = PW'(di);
		msb   = int'(j_q) == ACC_W - 1;
		t_re  = (dr[j_q] ? nr_w : '0) + (di[j_q] ? ni_w : '0);
		t_im  = (dr[j_q] ? ni_w : '0) - (di[j_q] ? nr_w : '0);
		t_den = (dr[j_q] ? dr_w : '0) + (di[j_q] ? di_w : '0);
		if (msb) begin
			t_re  = -t_re;
			t_im  = -t_im;
			t_den = -t_den;
		end
		mag_re = pre_q[PW-1] ? PW'(-pre_q) : PW'(pre_q);
		mag_im = pim_q[PW-1] ? PW'(-pim_q) : PW'(pim_q);
		den_u  = PW'(pden_q);
		lim_re = CMPW'({den_u, 31'b0}) + (pre_q[PW-1] ? CMPW'(den_u) : '0);
		lim_im = CMPW'({den_u, 31'b0}) + (pim_q[PW-1] ? CMPW'(den_u) : '0);
		s_re   = {rre_q, dre_q[QUOT_BITS-1]};
		s_im   = {rim_q, dim_q[QUOT_BITS-1]};
		ge_re  = s_re >= {1'b0, den_u};
		ge_im  = s_im >= {1'b0, den_u};
		f_re   = ovf_re_q ? (neg_re_q ? 32'h8000_0000 : 32'h7FFF_FFFF) : qre_q;
		f_im   = ovf_im_q ? (neg_im_q ? 32'h8000_0000 : 32'h7FFF_FFFF) : qim_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			go_q         <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
			quad_q       <= '0;
			z_q          <= '0;
			x_q          <= '0;
			y_q          <= '0;
			i_q          <= '0;
			cos_q        <= '0;
			msin_q       <= '0;
			j_q          <= '0;
			pre_q        <= '0;
			pim_q        <= '0;
			pden_q       <= '0;
			rre_q        <= '0;
			rim_q        <= '0;
			qre_q        <= '0;
			qim_q        <= '0;
			dre_q        <= '0;
			dim_q        <= '0;
			neg_re_q     <= 1'b0;
			neg_im_q     <= 1'b0;
			ovf_re_q     <= 1'b0;
			ovf_im_q     <= 1'b0;
			dc_q         <= '0;
		end else begin
			go_q         <= 1'b0;
			result_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (q_pop && q_item.kind == KIND_EVAL) begin
						quad_q  <= angle[PHASE_BITS+31 -: 2];
						z_q     <= ANG_BITS'({1'b0, angle[PHASE_BITS+29 -: 30]});
						x_q     <= CORDIC_GAIN;
						y_q     <= '0;
						i_q     <= '0;
						state_q <= B_CORDIC;
					end
				end
				B_CORDIC: begin
					if (!z_q[ANG_BITS-1]) begin
						x_q <= x_q - (y_q >>> i_q);
						y_q <= y_q + (x_q >>> i_q);
						z_q <= z_q - turn_atan(i_q);
					end else begin
						x_q <= x_q + (y_q >>> i_q);
						y_q <= y_q - (x_q >>> i_q);
						z_q <= z_q + turn_atan(i_q);
					end
					i_q <= i_q + 1'b1;
					if (int'(i_q) == CORDIC_STEPS - 1) begin
						state_q <= B_START;
					end
				end
				B_START: begin
					// quadrant fold, then z = cos - j sin
					case (quad_q)
						2'd0: begin
							cos_q  <= CS_BITS'(x_q);
							msin_q <= CS_BITS'(-y_q);
						end
						2'd1: begin
							cos_q  <= CS_BITS'(-y_q);
							msin_q <= CS_BITS'(-x_q);
						end
						2'd2: begin
							cos_q  <= CS_BITS'(-x_q);
							msin_q <= CS_BITS'(y_q);
						end
						default: begin
							cos_q  <= CS_BITS'(y_q);
							msin_q <= CS_BITS'(x_q);
						end
					endcase
					go_q    <= 1'b1;
					state_q <= B_HORNER;
				end
				B_HORNER: begin
					if (den_done && num_done) begin
						if (!den_nz) begin
							result       <= '{resp_real: '0, resp_imag: '0,
								status: STATUS_DEN_ZERO};
							result_valid <= 1'b1;
							state_q      <= B_IDLE;
						end else if (dr == '0 && di == '0) begin
							result       <= '{resp_real: '0, resp_imag: '0,
								status: STATUS_RANGE};
							result_valid <= 1'b1;
							state_q      <= B_IDLE;
						end else begin
							pre_q   <= '0;
							pim_q   <= '0;
							pden_q  <= '0;
							j_q     <= JW'(ACC_W - 1);
							state_q <= B_PROD;
						end
					end
				end
				B_PROD: begin
					// N*conj(D) and |D|^2, one multiplier bit of D per cycle
					pre_q  <= (pre_q <<< 1) + t_re;
					pim_q  <= (pim_q <<< 1) + t_im;
					pden_q <= (pden_q <<< 1) + t_den;
					j_q    <= j_q - 1'b1;
					if (j_q == '0) begin
						state_q <= B_RANGE;
					end
				end
				B_RANGE: begin
					neg_re_q <= pre_q[PW-1];
					neg_im_q <= pim_q[PW-1];
					ovf_re_q <= CMPW'({mag_re, 16'b0}) >= lim_re;
					ovf_im_q <= CMPW'({mag_im, 16'b0}) >= lim_im;
					rre_q    <= mag_re >> 16;
					rim_q    <= mag_im >> 16;
					dre_q    <= {mag_re[15:0], 16'b0};
					dim_q    <= {mag_im[15:0], 16'b0};
					qre_q    <= '0;
					qim_q    <= '0;
					dc_q     <= '0;
					state_q  <= B_DIV;
				end
				B_DIV: begin
					rre_q <= ge_re ? PW'(s_re - {1'b0, den_u}) : PW'(s_re);
					rim_q <= ge_im ? PW'(s_im - {1'b0, den_u}) : PW'(s_im);
					qre_q <= {qre_q[QUOT_BITS-2:0], ge_re};
					qim_q <= {qim_q[QUOT_BITS-2:0], ge_im};
					dre_q <= dre_q << 1;
					dim_q <= dim_q << 1;
					dc_q  <= dc_q + 1'b1;
					if (int'(dc_q) == QUOT_BITS - 1) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					result.resp_real <= neg_re_q ? $signed(-f_re) : $signed(f_re);
					result.resp_imag <= neg_im_q ? $signed(-f_im) : $signed(f_im);
					result.status    <= (ovf_re_q || ovf_im_q) ? STATUS_RANGE : STATUS_OK;
					result_valid     <= 1'b1;
					state_q          <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: bench/digital_frequency_response_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digital_frequency_response_unit_tb: self-checking bench of the response unit
// Drives coefficient writes and evaluate commands with random gaps, computes
// each expected H(e^jw) with an independent fixed-point model and compares
// every result field by field; tap counts are changed between phases.
// ----------------------------------------------------------------------------
module digital_frequency_response_unit_tb;
	import dfr_pkg::*;

	localparam int TAPS         = 16;
	localparam int WATCHDOG_MAX = 4000;
	localparam int SETTLE       = 200;
	localparam longint SUM_LIMIT = 64'sd1 << 54;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		bit                       is_cfg;
		logic [CFG_IDX_BITS-1:0]  cfg_sel;
		logic [CNT_BITS-1:0]      cfg_val;
		request_t                 req;
		bit                       fixed;
		result_t                  want;
	} stim_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	request_t                    request;
	logic                        cfg_we;
	logic [CFG_IDX_BITS-1:0]     cfg_index;
	logic [CNT_BITS-1:0]         cfg_data;
	logic                        result_valid;
	result_t                     result;

	digital_frequency_response_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	// model state
	longint              num_taps [TAPS];
	longint              den_taps [TAPS];
	logic [CNT_BITS-1:0] num_cnt;
	logic [CNT_BITS-1:0] den_cnt;

	result_t   response_q [$];
	stim_row_t directed [$];
	int        fail_count;
	int        resp_seen;
	int        write_count;
	int        eval_count;
	int        idle_cycles;

	localparam longint ATAN_TURN [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint mul_frac(input longint v, input longint w);
		logic signed [127:0] p;
		p = 128'(v) * 128'(w);
		return longint'(p >>> 30);
	endfunction

	function automatic int unsigned tap_limit(input logic [CNT_BITS-1:0] n);
		if (n == 0)
			return 1;
		return (n > TAPS) ? TAPS : n;
	endfunction

	function automatic void poly_eval(input bit use_den, input int unsigned n,
			input longint c, input longint ms, output longint re, output longint im);
		longint ar, ai, nr;
		ar = use_den ? den_taps[n-1] : num_taps[n-1];
		ai = 0;
		for (int k = n - 1; k > 0; k--) begin
			nr = mul_frac(ar, c) - mul_frac(ai, ms) + (use_den ? den_taps[k-1] : num_taps[k-1]);
			ai = mul_frac(ar, ms) + mul_frac(ai, c);
			ar = nr;
		end
		re = ar;
		im = ai;
	endfunction

	function automatic logic signed [31:0] clamp_q16(input logic signed [127:0] q,
			inout bit sat);
		if (q > 128'sh7FFFFFFF) begin
			sat = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (q < -128'sh80000000) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return q[31:0];
	endfunction

	function automatic result_t predict_response(input logic [PHASE_BITS-1:0] ph);
		result_t r;
		logic [31:0] angle;
		longint x, y, z, dx, dy, c, s, nr, ni, dr, di;
		logic signed [127:0] mag2, pr, pi;
		bit any_den, sat;
		int unsigned nb, na;
		r = '0;
		nb = tap_limit(num_cnt);
		na = tap_limit(den_cnt);
		any_den = 1'b0;
		for (int k = 0; k < na; k++)
			if (den_taps[k] != 0)
				any_den = 1'b1;
		if (!any_den) begin
			r.status = STATUS_DEN_ZERO;
			return r;
		end
		angle = {ph, 16'h0};
		z = longint'(angle[29:0]);
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TURN[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TURN[i];
			end
		end
		case (angle[31:30])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		poly_eval(1'b0, nb, c, -s, nr, ni);
		poly_eval(1'b1, na, c, -s, dr, di);
		// scale all four parts together until every one fits
		while (nr >= SUM_LIMIT || nr <= -SUM_LIMIT || ni >= SUM_LIMIT || ni <= -SUM_LIMIT ||
				dr >= SUM_LIMIT || dr <= -SUM_LIMIT || di >= SUM_LIMIT || di <= -SUM_LIMIT) begin
			nr = nr >>> 1; ni = ni >>> 1; dr = dr >>> 1; di = di >>> 1;
		end
		if (dr == 0 && di == 0) begin
			r.status = STATUS_RANGE;
			return r;
		end
		mag2 = 128'(dr) * 128'(dr) + 128'(di) * 128'(di);
		pr = 128'(nr) * 128'(dr) + 128'(ni) * 128'(di);
		pi = 128'(ni) * 128'(dr) - 128'(nr) * 128'(di);
		sat = 1'b0;
		r.resp_real = clamp_q16((pr <<< 16) / mag2, sat);
		r.resp_imag = clamp_q16((pi <<< 16) / mag2, sat);
		r.status = sat ? STATUS_RANGE : STATUS_OK;
		return r;
	endfunction

	// one command transaction; start may stay high into the next one
	task automatic issue(input request_t rq, input bit fixed, input result_t want);
		start <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		case (rq.command)
			CMD_WR_NUM: begin
				num_taps[rq.coeff_index] = longint'(rq.coeff_value);
				write_count++;
			end
			CMD_WR_DEN: begin
				den_taps[rq.coeff_index] = longint'(rq.coeff_value);
				write_count++;
			end
			CMD_EVAL: begin
				response_q.push_back(fixed ? want : predict_response(rq.phase));
				eval_count++;
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// registers change only with nothing in flight
	task automatic set_count(input logic [CFG_IDX_BITS-1:0] sel, input logic [CNT_BITS-1:0] val);
		start <= 1'b0;
		while (response_q.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (sel == CFG_NUM_COUNT)
			num_cnt = val;
		else
			den_cnt = val;
	endtask

	function automatic request_t mk_req(input logic [1:0] cmd, input logic [3:0] idx,
			input logic [31:0] val, input logic [15:0] ph);
		request_t rq;
		rq.command = cmd;
		rq.coeff_index = idx;
		rq.coeff_value = val;
		rq.phase = ph;
		return rq;
	endfunction

	function automatic void add_cmd(input request_t rq);
		stim_row_t row;
		row = '{default: '0};
		row.req = rq;
		directed.push_back(row);
	endfunction

	function automatic void add_known(input logic [15:0] ph, input result_t want);
		stim_row_t row;
		row = '{default: '0};
		row.req = mk_req(CMD_EVAL, 4'd0, 32'd0, ph);
		row.fixed = 1'b1;
		row.want = want;
		directed.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_BITS-1:0] sel, input logic [4:0] val);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.cfg_sel = sel;
		row.cfg_val = val;
		directed.push_back(row);
	endfunction

	function automatic logic [31:0] rand_coeff();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			3: return 32'($signed($urandom_range(0, 64)) - 32);
			default: return 32'($signed($urandom_range(0, 32'h07FFFFFF)) - 32'sh04000000);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			result_t exp_r;
			resp_seen++;
			if (response_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				fail_count++;
			end else begin
				exp_r = response_q.pop_front();
				if (result.resp_real !== exp_r.resp_real) begin
					$display("%0t: resp_real expected %h actual %h", $time,
						exp_r.resp_real, result.resp_real);
					fail_count++;
				end
				if (result.resp_imag !== exp_r.resp_imag) begin
					$display("%0t: resp_imag expected %h actual %h", $time,
						exp_r.resp_imag, result.resp_imag);
					fail_count++;
				end
				if (result.status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, result.status);
					fail_count++;
				end
			end
		end
	end

	// watchdog on transaction activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("%0t: no activity for %0d cycles", $time, WATCHDOG_MAX);
				$display("digital_frequency_response_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		result_t known;
		bit no_gaps;
		int seg_items;
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		resp_seen = 0;
		write_count = 0;
		eval_count = 0;
		idle_cycles = 0;
		for (int i = 0; i < TAPS; i++) begin
			num_taps[i] = 0;
			den_taps[i] = 0;
		end
		num_cnt = 5'd1;
		den_cnt = 5'd1;

		// directed table
		known = '0;
		known.status = STATUS_DEN_ZERO;
		add_known(16'h0000, known);
		add_cmd(mk_req(CMD_WR_DEN, 4'd0, 32'h01000000, 16'h0));
		add_cmd(mk_req(CMD_WR_NUM, 4'd0, 32'h01000000, 16'h0));
		known = '0;
		known.resp_real = 32'sd65536;
		add_known(16'hFFFF, known);
		add_cmd(mk_req(CMD_WR_DEN, 4'd0, 32'h00000001, 16'h0));
		add_cmd(mk_req(CMD_WR_NUM, 4'd0, 32'h7FFFFFFF, 16'h0));
		known = '0;
		known.resp_real = 32'sh7FFFFFFF;
		known.status = STATUS_RANGE;
		add_known(16'h8000, known);
		add_cmd(mk_req(CMD_WR_NUM, 4'd0, 32'h80000000, 16'h0));
		known.resp_real = 32'sh80000000;
		add_known(16'h4000, known);
		add_cmd(mk_req(CMD_UNUSED, 4'hF, 32'hFFFFFFFF, 16'hFFFF));
		add_cfg(CFG_NUM_COUNT, 5'd2);
		add_cfg(CFG_DEN_COUNT, 5'd2);
		add_cmd(mk_req(CMD_WR_DEN, 4'd0, 32'h00000001, 16'h0));
		add_cmd(mk_req(CMD_WR_DEN, 4'd1, 32'hFFFFFFFF, 16'h0));
		add_cmd(mk_req(CMD_WR_NUM, 4'd1, 32'h01000000, 16'h0));
		add_cmd(mk_req(CMD_EVAL, 4'd0, 32'd0, 16'h0000));
		add_cmd(mk_req(CMD_EVAL, 4'd0, 32'd0, 16'hC000));
		add_cfg(CFG_NUM_COUNT, 5'd31);
		add_cfg(CFG_DEN_COUNT, 5'd0);
		add_cmd(mk_req(CMD_WR_NUM, 4'hF, 32'h7FFFFFFF, 16'h0));
		add_cmd(mk_req(CMD_EVAL, 4'd0, 32'd0, 16'h2AAA));
		add_cfg(CFG_DEN_COUNT, 5'd16);
		add_cmd(mk_req(CMD_WR_DEN, 4'hF, 32'h7FFFFFFF, 16'h0));
		add_cmd(mk_req(CMD_EVAL, 4'd0, 32'd0, 16'h5555));
		add_cfg(CFG_NUM_COUNT, 5'd17);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg)
				set_count(directed[i].cfg_sel, directed[i].cfg_val);
			else begin
				issue(directed[i].req, directed[i].fixed, directed[i].want);
				pause(pick_gap());
			end
		end

		// random phases, each with its own tap counts
		for (int seg = 0; seg < 19; seg++) begin
			r = $urandom_range(0, 9);
			set_count(CFG_NUM_COUNT, r == 0 ? 5'($urandom_range(0, 31)) :
				r == 1 ? 5'd16 : 5'($urandom_range(1, 16)));
			r = $urandom_range(0, 9);
			set_count(CFG_DEN_COUNT, r == 0 ? 5'($urandom_range(0, 31)) :
				r == 1 ? 5'd1 : 5'($urandom_range(1, 16)));
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0)
				for (int k = 0; k < TAPS; k++)
					issue(mk_req(CMD_WR_DEN, 4'(k), 32'd0, 16'($urandom())), 1'b0, '0);
			seg_items = 100;
			for (int n = 0; n < seg_items; n++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					issue(mk_req(CMD_UNUSED, 4'($urandom()), $urandom(), 16'($urandom())),
						1'b0, '0);
				else if (r < 30)
					issue(mk_req(CMD_WR_NUM, 4'($urandom()), rand_coeff(), 16'($urandom())),
						1'b0, '0);
				else if (r < 55)
					issue(mk_req(CMD_WR_DEN, 4'($urandom()),
						$urandom_range(0, 7) == 0 ? 32'd0 : rand_coeff(), 16'($urandom())),
						1'b0, '0);
				else
					issue(mk_req(CMD_EVAL, 4'($urandom()), $urandom(), 16'($urandom())),
						1'b0, '0);
				if (!no_gaps)
					pause(pick_gap());
			end
		end

		start <= 1'b0;
		while (response_q.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("covered %0d coefficient writes and %0d evaluations, %0d results checked",
			write_count, eval_count, resp_seen);
		if (fail_count == 0)
			$display("digital_frequency_response_unit: match");
		else
			$display("digital_frequency_response_unit: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
design/dfr_pkg.sv
design/dfr_ram.sv
design/dfr_front.sv
design/dfr_horner.sv
design/dfr_back.sv
design/digital_frequency_response_unit.sv
bench/digital_frequency_response_unit_tb.sv
